// File: src/hjog_pkg.sv
// ----------------------------------------------------------------------------
// hjog_pkg
// Shared widths, register indexes, controller/datapath command and status
// types, and the divide-by-three helper of the Halton jitter generator.
// ----------------------------------------------------------------------------
package hjog_pkg;

  // Field and register widths.
  localparam int unsigned FRAME_W = 64;
  localparam int unsigned PC_W    = 11;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned OUT_W   = 24;
  localparam int unsigned FRAC_W  = 24;

  // n = phase + 1 never exceeds 2048, so twelve bits hold it. The base-3
  // reversed value stays below 3^7 = 2187, and its denominator is at most 3^7.
  localparam int unsigned N_W = 12;

  // Signed product of a 24-bit centered fraction and a 17-bit scale.
  localparam int unsigned MUL_W = FRAC_W + SCALE_W + 1;

  // Step counter covers the longest loop, the 64-step modulo.
  localparam int unsigned CNT_W = 6;
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(FRAME_W - 1);
  localparam logic [CNT_W-1:0] FRAC_LAST = CNT_W'(FRAC_W - 1);

  // Configuration register indexes.
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t REG_PHASE_COUNT  = 1'b0;
  localparam cfg_index_t REG_JITTER_SCALE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic dig_init;
    logic dig_step;
    logic frac_init;
    logic frac_step;
    logic mul_x;
    logic mul_y;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dig_zero;
    logic out_free;
  } status_t;

  // Quotient of a 12-bit value by three, by reciprocal multiplication.
  // 2731 / 8192 exceeds 1/3 by exactly 1/24576, which never carries the
  // product across an integer for values below 4096.
  function automatic logic [N_W-2:0] div3(input logic [N_W-1:0] v);
    logic [2*N_W-1:0] prod;
    prod = (2*N_W)'(v) * (2*N_W)'(2731);
    return prod[2*N_W-1:13];
  endfunction

endpackage

// File: src/hjog_ctrl.sv
// ----------------------------------------------------------------------------
// hjog_ctrl
// Sequencer of the jitter generator: steps the datapath through the modulo,
// the base-3 digit loop, the fraction division and the two scalings.
// ----------------------------------------------------------------------------
module hjog_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  hjog_pkg::status_t status,
  output hjog_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIG_INIT,
    ST_DIG,
    ST_FRAC_INIT,
    ST_FRAC,
    ST_MUL_X,
    ST_MUL_Y,
    ST_DONE
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic [hjog_pkg::CNT_W-1:0] cnt;
  logic [hjog_pkg::CNT_W-1:0] cnt_next;

  // Input is taken only between transactions.
  assign in_stall = (state != ST_IDLE);

  // Next state, step count and datapath commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == hjog_pkg::DIV_LAST) begin
          state_next = ST_DIG_INIT;
        end
      end
      ST_DIG_INIT: begin
        cmd.dig_init = 1'b1;
        state_next   = ST_DIG;
      end
      ST_DIG: begin
        if (status.dig_zero) begin
          state_next = ST_FRAC_INIT;
        end else begin
          cmd.dig_step = 1'b1;
        end
      end
      ST_FRAC_INIT: begin
        cmd.frac_init = 1'b1;
        cnt_next      = '0;
        state_next    = ST_FRAC;
      end
      ST_FRAC: begin
        cmd.frac_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == hjog_pkg::FRAC_LAST) begin
          state_next = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        cmd.mul_x  = 1'b1;
        state_next = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd.mul_y  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// File: src/hjog_dpath.sv
// ----------------------------------------------------------------------------
// hjog_dpath
// Datapath of the jitter generator: bit-serial modulo, base-3 digit
// reversal, restoring fraction division, shared scaling multiplier and the
// result register.
// ----------------------------------------------------------------------------
module hjog_dpath #(
  parameter int unsigned MAX_PHASE = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  hjog_pkg::cmd_t                      cmd,
  output hjog_pkg::status_t                   status,
  input  logic [hjog_pkg::FRAME_W-1:0]        frame_number,
  input  logic [hjog_pkg::PC_W-1:0]           phase_count,
  input  logic [hjog_pkg::SCALE_W-1:0]        jitter_scale,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [hjog_pkg::OUT_W-1:0]   offset_x,
  output logic signed [hjog_pkg::OUT_W-1:0]   offset_y
);

  localparam int unsigned PC_MAX = (1 << hjog_pkg::PC_W) - 1;
  localparam int unsigned CAP    = (MAX_PHASE < PC_MAX) ? MAX_PHASE : PC_MAX;
  localparam logic [hjog_pkg::PC_W-1:0] CAP_V = hjog_pkg::PC_W'(CAP);

  localparam int unsigned NW = hjog_pkg::N_W;
  localparam int unsigned FW = hjog_pkg::FRAC_W;

  // Working registers.
  logic [hjog_pkg::FRAME_W-1:0]       frame_sh;
  logic [hjog_pkg::PC_W-1:0]          rem;
  logic [NW-1:0]                      n_reg;
  logic [NW-1:0]                      dn;
  logic [NW-1:0]                      rev;
  logic [NW-1:0]                      den;
  logic [NW-1:0]                      frem;
  logic [FW-1:0]                      h3;
  logic signed [hjog_pkg::OUT_W-1:0]  x_res;
  logic signed [hjog_pkg::OUT_W-1:0]  y_res;

  // Combinational terms.
  logic [hjog_pkg::PC_W-1:0]          count;
  logic [NW-1:0]                      div_trial;
  logic                               div_ge;
  logic [NW-1:0]                      n_first;
  logic [NW-2:0]                      q3;
  logic [NW-1:0]                      q3x;
  logic [1:0]                         digit;
  logic [NW:0]                        rev3;
  logic [NW:0]                        den3;
  logic [NW:0]                        frac_trial;
  logic                               frac_ge;
  logic [FW-1:0]                      h2;
  logic [FW-1:0]                      h_sel;
  logic signed [FW-1:0]               centered;
  logic signed [hjog_pkg::SCALE_W:0]  scale_s;
  logic signed [hjog_pkg::MUL_W-1:0]  prod;

  // Effective phase count: zero acts as one, large values saturate.
  always_comb begin
    if (phase_count == '0) begin
      count = hjog_pkg::PC_W'(1);
    end else if (phase_count > CAP_V) begin
      count = CAP_V;
    end else begin
      count = phase_count;
    end
  end

  // One restoring step of frame_number modulo count.
  assign div_trial = {rem, frame_sh[hjog_pkg::FRAME_W-1]};
  assign div_ge    = (div_trial >= {1'b0, count});

  assign n_first = {1'b0, rem} + NW'(1);

  // Lowest base-3 digit of the remaining value.
  assign q3    = hjog_pkg::div3(dn);
  assign q3x   = NW'({q3, 1'b0}) + NW'(q3);
  assign digit = 2'(dn - q3x);
  assign rev3  = {rev, 1'b0} + (NW+1)'(rev) + (NW+1)'(digit);
  assign den3  = {den, 1'b0} + (NW+1)'(den);

  // One bit of rev / den as a binary fraction.
  assign frac_trial = {frem, 1'b0};
  assign frac_ge    = (frac_trial >= {1'b0, den});

  // Base-2 radical inverse: the bits of n mirrored about the binary point.
  always_comb begin
    h2 = '0;
    for (int i = 0; i < NW; i++) begin
      h2[FW-1-i] = n_reg[i];
    end
  end

  // Shared scaling: subtracting one half flips the top bit of the fraction,
  // and dropping 16 product bits of a signed value floors it.
  assign h_sel    = cmd.mul_y ? h3 : h2;
  assign centered = $signed({~h_sel[FW-1], h_sel[FW-2:0]});
  assign scale_s  = $signed({1'b0, jitter_scale});
  assign prod     = hjog_pkg::MUL_W'(centered) * hjog_pkg::MUL_W'(scale_s);

  // Arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_sh <= frame_number;
      rem      <= '0;
    end else if (cmd.div_step) begin
      frame_sh <= {frame_sh[hjog_pkg::FRAME_W-2:0], 1'b0};
      rem      <= div_ge ? hjog_pkg::PC_W'(div_trial - {1'b0, count})
                         : div_trial[hjog_pkg::PC_W-1:0];
    end

    if (cmd.dig_init) begin
      n_reg <= n_first;
      dn    <= n_first;
      rev   <= '0;
      den   <= NW'(1);
    end else if (cmd.dig_step) begin
      dn  <= {1'b0, q3};
      rev <= rev3[NW-1:0];
      den <= den3[NW-1:0];
    end

    if (cmd.frac_init) begin
      frem <= rev;
      h3   <= '0;
    end else if (cmd.frac_step) begin
      frem <= frac_ge ? NW'(frac_trial - {1'b0, den}) : frac_trial[NW-1:0];
      h3   <= {h3[FW-2:0], frac_ge};
    end

    if (cmd.mul_x) begin
      x_res <= prod[hjog_pkg::OUT_W+15:16];
    end
    if (cmd.mul_y) begin
      y_res <= prod[hjog_pkg::OUT_W+15:16];
    end

    if (cmd.out_load) begin
      offset_x <= x_res;
      offset_y <= y_res;
    end
  end

  // Result register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.dig_zero = (dn == '0);
  assign status.out_free = !out_valid || !out_stall;

endmodule

// File: src/halton_jitter_offset_generator_core.sv
// ----------------------------------------------------------------------------
// halton_jitter_offset_generator_core
// Sub-pixel jitter offsets from the base-2 and base-3 Halton sequences.
// ----------------------------------------------------------------------------
// Each transaction carries a frame number; the block reduces it modulo the
// phase count, forms n = phase + 1 and returns the base-2 and base-3 radical
// inverses of n, centered around zero and scaled by jitter_scale, as signed
// Q4.20 offsets. One transaction is worked on at a time, from acceptance to
// the result register: the bit-serial modulo, base-3 digit reversal (digit
// by digit, then a final zero check), the fraction division, the x and y
// scalings on the shared multiplier, and setup and handoff. The input
// reopens right after the handoff; a previous result still waiting
// downstream delays the handoff. The result register lets the next frame
// number be taken while a result still waits downstream.
// Configuration writes are registered and should be made while idle.
module halton_jitter_offset_generator_core #(
  parameter int unsigned MAX_PHASE = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  hjog_pkg::cfg_index_t               cfg_index,
  input  logic [hjog_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [hjog_pkg::FRAME_W-1:0]       frame_number,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [hjog_pkg::OUT_W-1:0]  offset_x,
  output logic signed [hjog_pkg::OUT_W-1:0]  offset_y
);

  logic [hjog_pkg::PC_W-1:0]    phase_count;
  logic [hjog_pkg::SCALE_W-1:0] jitter_scale;
  hjog_pkg::cmd_t               cmd;
  hjog_pkg::status_t            status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count  <= hjog_pkg::PC_W'(8);
      jitter_scale <= hjog_pkg::SCALE_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        hjog_pkg::REG_PHASE_COUNT: begin
          phase_count <= cfg_data[hjog_pkg::PC_W-1:0];
        end
        hjog_pkg::REG_JITTER_SCALE: begin
          jitter_scale <= cfg_data[hjog_pkg::SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  hjog_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  hjog_dpath #(
    .MAX_PHASE (MAX_PHASE)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .frame_number (frame_number),
    .phase_count  (phase_count),
    .jitter_scale (jitter_scale),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .offset_x     (offset_x),
    .offset_y     (offset_y)
  );

endmodule

// File: src/hjog_checker.sv
// ----------------------------------------------------------------------------
// hjog_checker
// Port-level checks of the jitter generator, bound to the top level.
// ----------------------------------------------------------------------------
module hjog_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [hjog_pkg::OUT_W-1:0]  offset_x,
  input logic signed [hjog_pkg::OUT_W-1:0]  offset_y
);

  // A stalled result stays put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(offset_x) && $stable(offset_y))
    else $error("stalled result changed or vanished");

  // Reset leaves the block empty and ready for a transaction.
  assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // An accepted transaction closes the input behind it.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input reopened while work in progress");

  // A new result appears only as the block finishes, with the input open.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result appeared while still busy");

endmodule

bind halton_jitter_offset_generator_core hjog_checker u_hjog_checker (.*);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Halton jitter offset generator. Frame numbers
// are fed from a queue through a valid/stall driver. A monitor compares each
// returned offset pair with a locally computed prediction under several
// phase count and jitter scale settings, including the extremes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PHASE   = 1024;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 120;

  typedef struct {
    logic signed [hjog_pkg::OUT_W-1:0] x;
    logic signed [hjog_pkg::OUT_W-1:0] y;
  } offset_pair_t;

  logic                               clk          = 1'b0;
  logic                               rst          = 1'b1;
  logic                               cfg_we       = 1'b0;
  hjog_pkg::cfg_index_t               cfg_index    = hjog_pkg::REG_PHASE_COUNT;
  logic [hjog_pkg::CFG_W-1:0]         cfg_data     = '0;
  logic                               in_valid     = 1'b0;
  logic                               in_stall;
  logic [hjog_pkg::FRAME_W-1:0]       frame_number = '0;
  logic                               out_valid;
  logic                               out_stall    = 1'b0;
  logic signed [hjog_pkg::OUT_W-1:0]  offset_x;
  logic signed [hjog_pkg::OUT_W-1:0]  offset_y;

  // Shadow copies of the configuration registers.
  logic [hjog_pkg::PC_W-1:0]    cur_phase_count  = hjog_pkg::PC_W'(8);
  logic [hjog_pkg::SCALE_W-1:0] cur_jitter_scale = hjog_pkg::SCALE_W'(4096);

  logic [hjog_pkg::FRAME_W-1:0] frame_queue[$];
  offset_pair_t                 offsets_expected[$];
  bit                           idle_en    = 1'b1;
  int unsigned                  mismatches = 0;
  int unsigned                  cycle_count = 0;

  halton_jitter_offset_generator_core #(
    .MAX_PHASE(MAX_PHASE)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .frame_number (frame_number),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .offset_x     (offset_x),
    .offset_y     (offset_y)
  );

  always #5 clk = ~clk;

  // Radical inverse of n in the given base, truncated to a Q0.24 fraction.
  function automatic longint unsigned radical_inverse_q24(int unsigned n, int unsigned base);
    longint unsigned digits_rev;
    longint unsigned denom;
    digits_rev = 0;
    denom      = 1;
    while (n > 0) begin
      digits_rev = digits_rev * base + n % base;
      n          = n / base;
      denom      = denom * base;
    end
    return (digits_rev << hjog_pkg::FRAC_W) / denom;
  endfunction

  // Center a Q0.24 fraction around zero and scale it into Q4.20, rounding down.
  function automatic logic signed [hjog_pkg::OUT_W-1:0] center_and_scale(
      longint unsigned frac, logic [hjog_pkg::SCALE_W-1:0] scale);
    longint centered;
    longint product;
    centered = longint'(frac) - longint'(64'd1 << (hjog_pkg::FRAC_W - 1));
    product  = centered * longint'({48'd0, scale});
    return hjog_pkg::OUT_W'(product >>> 16);
  endfunction

  // Offsets for one frame number under the current register settings.
  function automatic offset_pair_t halton_offsets(logic [hjog_pkg::FRAME_W-1:0] frame);
    logic [hjog_pkg::FRAME_W-1:0] cycle_len;
    int unsigned                  n;
    offset_pair_t                 pair;
    cycle_len = hjog_pkg::FRAME_W'(cur_phase_count);
    if (cycle_len == 0) begin
      cycle_len = 1;
    end
    if (cycle_len > MAX_PHASE) begin
      cycle_len = MAX_PHASE;
    end
    n      = int'(frame % cycle_len) + 1;
    pair.x = center_and_scale(radical_inverse_q24(n, 2), cur_jitter_scale);
    pair.y = center_and_scale(radical_inverse_q24(n, 3), cur_jitter_scale);
    return pair;
  endfunction

  function automatic int unsigned draw_wait();
    return idle_en ? $urandom_range(0, 5) : 0;
  endfunction

  // Driver: presents queued frame numbers and records the prediction when a
  // transaction is accepted.
  always @(posedge clk) begin : driver
    logic        next_valid;
    int unsigned send_gap;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        offsets_expected.push_back(halton_offsets(frame_number));
      end
      next_valid = in_valid && in_stall;
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (frame_queue.size() != 0) begin
          frame_number <= frame_queue.pop_front();
          next_valid = 1'b1;
          send_gap   = draw_wait();
        end
      end
      in_valid <= next_valid;
    end
  end

  // Monitor: checks each accepted result against the oldest prediction and,
  // after taking it, may hold off the next result for a random wait.
  always @(posedge clk) begin : monitor
    offset_pair_t want;
    int unsigned  stall_left;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      if (offsets_expected.size() == 0) begin
        $error("Unexpected result: offset_x %0d, offset_y %0d", offset_x, offset_y);
        mismatches++;
      end else begin
        want = offsets_expected.pop_front();
        if (offset_x !== want.x) begin
          $error("offset_x mismatch: expected %0d, actual %0d", want.x, offset_x);
          mismatches++;
        end
        if (offset_y !== want.y) begin
          $error("offset_y mismatch: expected %0d, actual %0d", want.y, offset_y);
          mismatches++;
        end
      end
      // Wait time for the next result.
      stall_left = draw_wait();
      out_stall <= (stall_left != 0);
    end else if (out_valid && out_stall) begin
      if (stall_left > 0) begin
        stall_left--;
      end
      if (stall_left == 0) begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_register(hjog_pkg::cfg_index_t idx,
                                logic [hjog_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == hjog_pkg::REG_PHASE_COUNT) begin
      cur_phase_count = data[hjog_pkg::PC_W-1:0];
    end else begin
      cur_jitter_scale = data[hjog_pkg::SCALE_W-1:0];
    end
  endtask

  task automatic set_config(logic [hjog_pkg::CFG_W-1:0] phase_data,
                            logic [hjog_pkg::CFG_W-1:0] scale_data);
    write_register(hjog_pkg::REG_PHASE_COUNT, phase_data);
    write_register(hjog_pkg::REG_JITTER_SCALE, scale_data);
  endtask

  // Holds the sender until every queued transaction has returned its result.
  task automatic drain();
    while (frame_queue.size() != 0 || in_valid || offsets_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [hjog_pkg::FRAME_W-1:0] random_frame();
    logic [hjog_pkg::FRAME_W-1:0] full;
    full = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       return hjog_pkg::FRAME_W'($urandom_range(0, 3000));
      1:       return ~hjog_pkg::FRAME_W'($urandom_range(0, 3000));
      default: return full;
    endcase
  endfunction

  function automatic logic [hjog_pkg::CFG_W-1:0] random_phase_data();
    case ($urandom_range(0, 5))
      0:       return hjog_pkg::CFG_W'($urandom_range(0, 3));
      1:       return hjog_pkg::CFG_W'($urandom_range(4, 64));
      2:       return hjog_pkg::CFG_W'(MAX_PHASE);
      3:       return hjog_pkg::CFG_W'($urandom_range(MAX_PHASE + 1, 2047));
      4:       return hjog_pkg::CFG_W'($urandom);
      default: return hjog_pkg::CFG_W'($urandom_range(0, MAX_PHASE));
    endcase
  endfunction

  function automatic logic [hjog_pkg::CFG_W-1:0] random_scale_data();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return hjog_pkg::CFG_W'(4096);
      default: return hjog_pkg::CFG_W'($urandom);
    endcase
  endfunction

  // Stimulus and end of test.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Reset settings: one full cycle of eight phases plus the wrap points.
    for (int i = 0; i < 8; i++) begin
      frame_queue.push_back(hjog_pkg::FRAME_W'(i));
    end
    frame_queue.push_back('1);
    frame_queue.push_back(hjog_pkg::FRAME_W'(8));
    drain();

    // Zero phase count acts as one, with the largest scale.
    set_config('0, '1);
    frame_queue.push_back('0);
    frame_queue.push_back('1);
    drain();

    // Largest legal phase count with zero scale.
    set_config(hjog_pkg::CFG_W'(MAX_PHASE), '0);
    frame_queue.push_back(hjog_pkg::FRAME_W'(1023));
    frame_queue.push_back(hjog_pkg::FRAME_W'(1024));
    frame_queue.push_back('1);
    drain();

    // Phase count above the maximum saturates; upper data bits are dropped.
    set_config('1, '1);
    frame_queue.push_back(hjog_pkg::FRAME_W'(1023));
    frame_queue.push_back(hjog_pkg::FRAME_W'(2047));
    frame_queue.push_back('0);
    drain();

    // Radical inverses close to zero and to one at full scale.
    set_config(hjog_pkg::CFG_W'(MAX_PHASE), '1);
    frame_queue.push_back(hjog_pkg::FRAME_W'(511));
    frame_queue.push_back(hjog_pkg::FRAME_W'(1022));
    frame_queue.push_back(hjog_pkg::FRAME_W'(728));
    drain();

    // Random settings, each followed by a burst of random frame numbers.
    for (int ph = 0; ph < 12; ph++) begin
      idle_en = (ph != 3);
      set_config(random_phase_data(), random_scale_data());
      for (int i = 0; i < 120; i++) begin
        frame_queue.push_back(random_frame());
      end
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (offsets_expected.size() != 0) begin
      $error("%0d results never arrived", offsets_expected.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: halton_jitter_offset_generator_core.f
src/hjog_pkg.sv
src/hjog_ctrl.sv
src/hjog_dpath.sv
src/halton_jitter_offset_generator_core.sv
src/hjog_checker.sv
dv/tb.sv
